// ===== hdl/mocu_pkg.sv =====
`timescale 1ns / 1ps

package mocu_pkg;

   localparam int LANE_BITS = 8;
   localparam int NUM_LANES = 8;
   localparam int POS_W     = 9;
   localparam int DEG_W     = 11;
   localparam int TDEG_W    = 12;

   localparam logic [2:0] OP_CMP_XA    = 3'd0;
   localparam logic [2:0] OP_CMP_XAB   = 3'd1;
   localparam logic [2:0] OP_DIVISIBLE = 3'd2;
   localparam logic [2:0] OP_MUL       = 3'd3;
   localparam logic [2:0] OP_DIV       = 3'd4;
   localparam logic [2:0] OP_GCD_DEG   = 3'd5;
   localparam logic [2:0] OP_LCM_DEG   = 3'd6;

   localparam logic [1:0] MODE_LEX       = 2'd0;
   localparam logic [1:0] MODE_DEGREVLEX = 2'd1;
   localparam logic [1:0] MODE_ALEX      = 2'd2;

   localparam logic [1:0] ERR_OK           = 2'd0;
   localparam logic [1:0] ERR_SAT          = 2'd1;
   localparam logic [1:0] ERR_NOT_DIV      = 2'd2;
   localparam logic [1:0] ERR_POS_CONFLICT = 2'd3;

   localparam logic signed [1:0] ORD_GT = 2'sb01;
   localparam logic signed [1:0] ORD_EQ = 2'sb00;
   localparam logic signed [1:0] ORD_LT = 2'sb11;

   localparam logic signed [POS_W-1:0] POS_NONE = -9'sd1;

   typedef struct packed {
      logic ne;
      logic gt;
      logic ge;
      logic sat;
   } lane_flags_type;

endpackage

// ===== hdl/mocu_lane.sv =====
`timescale 1ns / 1ps

module mocu_lane #(
   parameter int EXP_BITS = 8
) (
   input  logic [EXP_BITS-1:0]     x,
   input  logic [EXP_BITS-1:0]     a,
   input  logic [EXP_BITS-1:0]     b,
   input  logic                    cmp_ab,
   output mocu_pkg::lane_flags_type flags,
   output logic [EXP_BITS-1:0]     prod,
   output logic [EXP_BITS-1:0]     quot,
   output logic [EXP_BITS-1:0]     min_val,
   output logic [EXP_BITS-1:0]     max_val,
   output logic [EXP_BITS:0]       target
);
   import mocu_pkg::*;

   logic [EXP_BITS:0] sum_xa;
   logic [EXP_BITS:0] x_ext;

   assign x_ext  = {1'b0, x};
   assign sum_xa = x_ext + {1'b0, a};
   // compare target is the exact unsaturated a+b for the product compare
   assign target = cmp_ab ? ({1'b0, a} + {1'b0, b}) : {1'b0, a};

   assign flags.sat = sum_xa[EXP_BITS];
   assign flags.ge  = (x >= a);
   assign flags.ne  = (x_ext != target);
   assign flags.gt  = (x_ext > target);

   assign prod    = sum_xa[EXP_BITS] ? {EXP_BITS{1'b1}} : sum_xa[EXP_BITS-1:0];
   assign quot    = x - a;
   assign min_val = (x <= a) ? x : a;
   assign max_val = (x <= a) ? a : x;

endmodule

// ===== hdl/monomial_order_compare_unit_core.sv =====
`timescale 1ns / 1ps

// monomial compare and arithmetic unit, fully pipelined
// request: drive req_* with start high; a transaction is taken at every
// clock edge with start high and busy low. busy is always low, so one
// transaction can enter every cycle.
// response: rsp_strobe is high for exactly one cycle with the rsp_* fields,
// after the three register stages (lane compute, lane select with
// partial degree sums, final sums and order decision). the result ports
// hold their values only for that cycle; the receiver cannot stall and
// nothing in the pipe waits on it.
// throughput: one transaction per cycle through the three register stages.
// csr: csr_we writes csr_wdata into the order mode (0 lex, 1 degree
// reverse-scan lex, 2 alex, 3 as lex); write only while the pipe is empty.
// reset (synchronous): drops all in-flight transactions and sets lex order.
module monomial_order_compare_unit_core #(
   parameter int NUM_VARS = 8,
   parameter int EXP_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_operation,
   input  logic [63:0]                        req_exps_x,
   input  logic [63:0]                        req_exps_a,
   input  logic [63:0]                        req_exps_b,
   input  logic signed [mocu_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [mocu_pkg::POS_W-1:0]  req_pos_a,
   output logic                               rsp_strobe,
   output logic signed [1:0]                  rsp_order_result,
   output logic                               rsp_is_divisible,
   output logic [mocu_pkg::DEG_W-1:0]         rsp_degree_value,
   output logic [63:0]                        rsp_result_exps,
   output logic signed [mocu_pkg::POS_W-1:0]  rsp_result_pos,
   output logic [1:0]                         rsp_error_code,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_wdata
);
   import mocu_pkg::*;

   localparam int HALF = (NUM_VARS + 1) / 2;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // order mode register
   logic [1:0] order_mode_ff, order_mode_in;
   assign order_mode_in = csr_we ? csr_wdata : order_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= MODE_LEX;
      end else begin
         order_mode_ff <= order_mode_in;
      end
   end

   // ---------------- stage 1: per-lane compute ----------------
   lane_flags_type      lane_flags [NUM_VARS];
   logic [EXP_BITS-1:0] lane_prod  [NUM_VARS];
   logic [EXP_BITS-1:0] lane_quot  [NUM_VARS];
   logic [EXP_BITS-1:0] lane_min   [NUM_VARS];
   logic [EXP_BITS-1:0] lane_max   [NUM_VARS];
   logic [EXP_BITS:0]   lane_tgt   [NUM_VARS];
   logic [EXP_BITS-1:0] lane_x     [NUM_VARS];

   for (genvar g = 0; g < NUM_VARS; g++) begin : g_lane
      assign lane_x[g] = req_exps_x[LANE_BITS*g +: EXP_BITS];
      mocu_lane #(.EXP_BITS(EXP_BITS)) u_lane (
         .x       (req_exps_x[LANE_BITS*g +: EXP_BITS]),
         .a       (req_exps_a[LANE_BITS*g +: EXP_BITS]),
         .b       (req_exps_b[LANE_BITS*g +: EXP_BITS]),
         .cmp_ab  (req_operation == OP_CMP_XAB),
         .flags   (lane_flags[g]),
         .prod    (lane_prod[g]),
         .quot    (lane_quot[g]),
         .min_val (lane_min[g]),
         .max_val (lane_max[g]),
         .target  (lane_tgt[g])
      );
   end

   logic ge_all_in, sat_any_in;
   always_comb begin
      ge_all_in  = 1'b1;
      sat_any_in = 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
         ge_all_in  = ge_all_in & lane_flags[i].ge;
         sat_any_in = sat_any_in | lane_flags[i].sat;
      end
   end

   logic                    s1_valid_ff, s1_valid_in;
   logic [2:0]              s1_op_ff, s1_op_in;
   logic [1:0]              s1_mode_ff, s1_mode_in;
   logic signed [POS_W-1:0] s1_px_ff, s1_px_in;
   logic signed [POS_W-1:0] s1_pa_ff, s1_pa_in;
   logic                    s1_ge_all_ff, s1_ge_all_in;
   logic                    s1_sat_any_ff, s1_sat_any_in;
   lane_flags_type          s1_flags_ff [NUM_VARS];
   logic [EXP_BITS-1:0]     s1_x_ff     [NUM_VARS];
   logic [EXP_BITS-1:0]     s1_prod_ff  [NUM_VARS];
   logic [EXP_BITS-1:0]     s1_quot_ff  [NUM_VARS];
   logic [EXP_BITS-1:0]     s1_min_ff   [NUM_VARS];
   logic [EXP_BITS-1:0]     s1_max_ff   [NUM_VARS];
   logic [EXP_BITS:0]       s1_tgt_ff   [NUM_VARS];

   assign s1_valid_in   = accept;
   assign s1_op_in      = req_operation;
   assign s1_mode_in    = order_mode_ff;
   assign s1_px_in      = req_pos_x;
   assign s1_pa_in      = req_pos_a;
   assign s1_ge_all_in  = ge_all_in;
   assign s1_sat_any_in = sat_any_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff      <= s1_op_in;
      s1_mode_ff    <= s1_mode_in;
      s1_px_ff      <= s1_px_in;
      s1_pa_ff      <= s1_pa_in;
      s1_ge_all_ff  <= s1_ge_all_in;
      s1_sat_any_ff <= s1_sat_any_in;
      for (int i = 0; i < NUM_VARS; i++) begin
         s1_flags_ff[i] <= lane_flags[i];
         s1_x_ff[i]     <= lane_x[i];
         s1_prod_ff[i]  <= lane_prod[i];
         s1_quot_ff[i]  <= lane_quot[i];
         s1_min_ff[i]   <= lane_min[i];
         s1_max_ff[i]   <= lane_max[i];
         s1_tgt_ff[i]   <= lane_tgt[i];
      end
   end

   // ---------------- stage 2: select, scan, half sums ----------------
   logic                    px_none, pa_none, pos_ok;
   logic [1:0]              err_c;
   logic signed [POS_W-1:0] pos_c;
   logic                    div_c;
   logic                    use_x;
   logic [63:0]             exps_c;
   logic signed [1:0]       lex_c, rev_c;
   logic                    lex_found, rev_found;
   logic [DEG_W-1:0]        deg_lo_c, deg_hi_c, dx_lo_c, dx_hi_c;
   logic [TDEG_W-1:0]       dt_lo_c, dt_hi_c;
   logic [EXP_BITS-1:0]     e_lane;
   logic [EXP_BITS-1:0]     dv_lane;

   assign px_none = (s1_px_ff == POS_NONE);
   assign pa_none = (s1_pa_ff == POS_NONE);
   assign pos_ok  = pa_none || (s1_px_ff == s1_pa_ff);

   always_comb begin
      err_c = ERR_OK;
      pos_c = POS_NONE;
      div_c = 1'b0;
      use_x = 1'b1;
      case (s1_op_ff)
         OP_DIVISIBLE: begin
            div_c = pos_ok && s1_ge_all_ff;
         end
         OP_MUL: begin
            pos_c = px_none ? s1_pa_ff : s1_px_ff;
            if (!px_none && !pa_none) begin
               err_c = ERR_POS_CONFLICT;
            end else begin
               use_x = 1'b0;
               if (s1_sat_any_ff) begin
                  err_c = ERR_SAT;
               end
            end
         end
         OP_DIV: begin
            pos_c = s1_px_ff;
            if (!pos_ok) begin
               err_c = ERR_POS_CONFLICT;
            end else if (!s1_ge_all_ff) begin
               err_c = ERR_NOT_DIV;
            end else begin
               use_x = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      exps_c   = '0;
      deg_lo_c = '0;
      deg_hi_c = '0;
      dx_lo_c  = '0;
      dx_hi_c  = '0;
      dt_lo_c  = '0;
      dt_hi_c  = '0;
      e_lane   = '0;
      dv_lane  = '0;
      for (int i = 0; i < NUM_VARS; i++) begin
         if (use_x) begin
            e_lane = s1_x_ff[i];
         end else if (s1_op_ff == OP_MUL) begin
            e_lane = s1_prod_ff[i];
         end else begin
            e_lane = s1_quot_ff[i];
         end
         case (s1_op_ff)
            OP_MUL, OP_DIV: dv_lane = e_lane;
            OP_GCD_DEG:     dv_lane = s1_min_ff[i];
            OP_LCM_DEG:     dv_lane = s1_max_ff[i];
            default:        dv_lane = '0;
         endcase
         if (s1_op_ff == OP_MUL || s1_op_ff == OP_DIV) begin
            exps_c[LANE_BITS*i +: LANE_BITS] = LANE_BITS'(e_lane);
         end
         if (i < HALF) begin
            deg_lo_c = deg_lo_c + DEG_W'(dv_lane);
            dx_lo_c  = dx_lo_c + DEG_W'(s1_x_ff[i]);
            dt_lo_c  = dt_lo_c + TDEG_W'(s1_tgt_ff[i]);
         end else begin
            deg_hi_c = deg_hi_c + DEG_W'(dv_lane);
            dx_hi_c  = dx_hi_c + DEG_W'(s1_x_ff[i]);
            dt_hi_c  = dt_hi_c + TDEG_W'(s1_tgt_ff[i]);
         end
      end
   end

   // first difference from variable 0 up, and from the last variable down
   always_comb begin
      lex_c     = ORD_EQ;
      lex_found = 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
         if (!lex_found && s1_flags_ff[i].ne) begin
            lex_found = 1'b1;
            lex_c     = s1_flags_ff[i].gt ? ORD_GT : ORD_LT;
         end
      end
      rev_c     = ORD_EQ;
      rev_found = 1'b0;
      for (int i = NUM_VARS - 1; i >= 0; i--) begin
         if (!rev_found && s1_flags_ff[i].ne) begin
            rev_found = 1'b1;
            rev_c     = s1_flags_ff[i].gt ? ORD_LT : ORD_GT;
         end
      end
   end

   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_cmp_ff, s2_cmp_in;
   logic [1:0]              s2_mode_ff, s2_mode_in;
   logic [1:0]              s2_err_ff, s2_err_in;
   logic signed [POS_W-1:0] s2_pos_ff, s2_pos_in;
   logic                    s2_div_ff, s2_div_in;
   logic [63:0]             s2_exps_ff, s2_exps_in;
   logic signed [1:0]       s2_lex_ff, s2_lex_in;
   logic signed [1:0]       s2_rev_ff, s2_rev_in;
   logic [DEG_W-1:0]        s2_deg_lo_ff, s2_deg_lo_in, s2_deg_hi_ff, s2_deg_hi_in;
   logic [DEG_W-1:0]        s2_dx_lo_ff, s2_dx_lo_in, s2_dx_hi_ff, s2_dx_hi_in;
   logic [TDEG_W-1:0]       s2_dt_lo_ff, s2_dt_lo_in, s2_dt_hi_ff, s2_dt_hi_in;

   assign s2_valid_in  = s1_valid_ff;
   assign s2_cmp_in    = (s1_op_ff == OP_CMP_XA) || (s1_op_ff == OP_CMP_XAB);
   assign s2_mode_in   = s1_mode_ff;
   assign s2_err_in    = err_c;
   assign s2_pos_in    = pos_c;
   assign s2_div_in    = div_c;
   assign s2_exps_in   = exps_c;
   assign s2_lex_in    = lex_c;
   assign s2_rev_in    = rev_c;
   assign s2_deg_lo_in = deg_lo_c;
   assign s2_deg_hi_in = deg_hi_c;
   assign s2_dx_lo_in  = dx_lo_c;
   assign s2_dx_hi_in  = dx_hi_c;
   assign s2_dt_lo_in  = dt_lo_c;
   assign s2_dt_hi_in  = dt_hi_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_cmp_ff    <= s2_cmp_in;
      s2_mode_ff   <= s2_mode_in;
      s2_err_ff    <= s2_err_in;
      s2_pos_ff    <= s2_pos_in;
      s2_div_ff    <= s2_div_in;
      s2_exps_ff   <= s2_exps_in;
      s2_lex_ff    <= s2_lex_in;
      s2_rev_ff    <= s2_rev_in;
      s2_deg_lo_ff <= s2_deg_lo_in;
      s2_deg_hi_ff <= s2_deg_hi_in;
      s2_dx_lo_ff  <= s2_dx_lo_in;
      s2_dx_hi_ff  <= s2_dx_hi_in;
      s2_dt_lo_ff  <= s2_dt_lo_in;
      s2_dt_hi_ff  <= s2_dt_hi_in;
   end

   // ---------------- stage 3: final sums and order decision ----------------
   logic [TDEG_W-1:0] dx_c, dt_c;
   logic [DEG_W-1:0]  deg_c;
   logic signed [1:0] ord_c;

   assign dx_c  = TDEG_W'(s2_dx_lo_ff) + TDEG_W'(s2_dx_hi_ff);
   assign dt_c  = s2_dt_lo_ff + s2_dt_hi_ff;
   assign deg_c = s2_deg_lo_ff + s2_deg_hi_ff;

   always_comb begin
      ord_c = ORD_EQ;
      if (s2_cmp_ff) begin
         case (s2_mode_ff)
            MODE_DEGREVLEX: begin
               if (dx_c != dt_c) begin
                  ord_c = (dx_c > dt_c) ? ORD_GT : ORD_LT;
               end else begin
                  ord_c = s2_rev_ff;
               end
            end
            MODE_ALEX: begin
               if (dx_c != dt_c) begin
                  ord_c = (dx_c > dt_c) ? ORD_LT : ORD_GT;
               end else begin
                  ord_c = s2_lex_ff;
               end
            end
            default: ord_c = s2_lex_ff;
         endcase
      end
   end

   logic                    s3_valid_ff, s3_valid_in;
   logic signed [1:0]       s3_ord_ff, s3_ord_in;
   logic                    s3_div_ff, s3_div_in;
   logic [DEG_W-1:0]        s3_deg_ff, s3_deg_in;
   logic [63:0]             s3_exps_ff, s3_exps_in;
   logic signed [POS_W-1:0] s3_pos_ff, s3_pos_in;
   logic [1:0]              s3_err_ff, s3_err_in;

   assign s3_valid_in = s2_valid_ff;
   assign s3_ord_in   = ord_c;
   assign s3_div_in   = s2_div_ff;
   assign s3_deg_in   = deg_c;
   assign s3_exps_in  = s2_exps_ff;
   assign s3_pos_in   = s2_pos_ff;
   assign s3_err_in   = s2_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_ord_ff  <= s3_ord_in;
      s3_div_ff  <= s3_div_in;
      s3_deg_ff  <= s3_deg_in;
      s3_exps_ff <= s3_exps_in;
      s3_pos_ff  <= s3_pos_in;
      s3_err_ff  <= s3_err_in;
   end

   assign rsp_strobe       = s3_valid_ff;
   assign rsp_order_result = s3_ord_ff;
   assign rsp_is_divisible = s3_div_ff;
   assign rsp_degree_value = s3_deg_ff;
   assign rsp_result_exps  = s3_exps_ff;
   assign rsp_result_pos   = s3_pos_ff;
   assign rsp_error_code   = s3_err_ff;

   // ---------------- checks ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted transaction did not respond after three cycles");

   a_ord_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_order_result != 2'sb10))
      else $error("order result carries an unused code");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_order_result != ORD_EQ) |->
         (rsp_degree_value == '0 && rsp_error_code == ERR_OK && !rsp_is_divisible))
      else $error("compare result mixed with arithmetic fields");

   a_div_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_divisible) |->
         (rsp_result_pos == POS_NONE && rsp_result_exps == '0))
      else $error("divisible test returned arithmetic payload");

endmodule
